// ----- rtl/i2crb_pkg.sv -----
package i2crb_pkg;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd4;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // Register index, taken from paddr[2].
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [2:0] BYTES_SENT    = 3'd3;
    localparam logic [2:0] RESTART_INDEX = 3'd2;

    typedef enum logic [4:0] {
        P_IDLE       = 5'd0,
        P_START_HI   = 5'd1,
        P_START_FALL = 5'd2,
        P_START_LOW  = 5'd3,
        P_BIT_SET    = 5'd4,
        P_BIT_HI     = 5'd5,
        P_BIT_LO     = 5'd6,
        P_ACK_REL    = 5'd7,
        P_ACK_HI     = 5'd8,
        P_ACK_POLL   = 5'd9,
        P_RD_HI      = 5'd10,
        P_RD_SAMPLE  = 5'd11,
        P_NACK_REL   = 5'd12,
        P_NACK_HI    = 5'd13,
        P_NACK_LO    = 5'd14,
        P_STOP_A     = 5'd15,
        P_STOP_B     = 5'd16,
        P_STOP_C     = 5'd17,
        P_FINISH     = 5'd18
    } t_phase;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_result;
        logic       no_ack;
    } t_result;

endpackage

// ----- rtl/i2c_register_byte_master.sv -----
// I2C master for single-byte register writes and reads.
// Input channel (i_valid / o_ready): one transaction per bus tick. It carries
// the sampled SDA level and, while the master is idle, an optional command
// (i_cmd_valid, i_opcode, device byte, register address, write data).
// Output channel (o_valid / i_ready): one result per accepted tick with the
// driven SCL and SDA levels, busy and done flags, the last read byte and the
// no-acknowledge flag.
// The result of a tick is registered into the output register, or into the
// skid register while the output is stalled. Throughput is one tick per cycle
// while o_ready is high; the sequencer state updates on each accepted tick.
// When the receiver stalls, one further result is caught in a skid register
// and o_ready then drops until the output drains; nothing is lost.
// The APB port holds the half period (address 0) and the ACK timeout
// (address 4); it should be written only while the master is idle.
// A synchronous active-low reset returns the sequencer to idle with both
// lines released high, empties the output stages and restores the register
// defaults of 4 ticks and 250 polls.
module i2c_register_byte_master (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd_valid,
    input  logic                 i_opcode,
    input  logic [7:0]           i_device_byte,
    input  logic [7:0]           i_reg_addr,
    input  logic [7:0]           i_write_data,
    input  logic                 i_sda_in,
    // output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_scl_level,
    output logic                 o_sda_level,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [7:0]           o_read_result,
    output logic                 o_no_ack,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import i2crb_pkg::*;

    // Configuration registers.
    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;

    // Sequencer state.
    t_phase      r_phase, n_phase;
    logic [15:0] r_wait_count, n_wait_count;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [2:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_shifter, n_shifter;
    logic [7:0]  r_ack_polls, n_ack_polls;
    logic        r_cmd_op, n_cmd_op;
    logic [7:0]  r_cmd_dev, n_cmd_dev;
    logic [7:0]  r_cmd_reg, n_cmd_reg;
    logic [7:0]  r_cmd_data, n_cmd_data;
    logic [7:0]  r_read_hold, n_read_hold;
    logic        r_error, n_error;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        n_done;

    // Output register and skid stage.
    t_result     r_out, r_skid, w_result;
    logic        r_out_valid, r_skid_valid;

    logic        w_accept;
    logic        w_idle;
    logic        w_run;
    t_phase      w_step;
    logic [2:0]  w_bi_inc;
    logic [3:0]  w_bc_inc;
    logic [7:0]  w_rd_shift;
    logic        w_cfg_write;

    function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic op,
                                            input logic [7:0] dev, input logic [7:0] rga,
                                            input logic [7:0] dat);
        logic [7:0] b;
        if (idx == 3'd0) begin
            b = dev;
        end else if (idx == 3'd1) begin
            b = rga;
        end else if (op == OP_READ) begin
            b = dev + 8'd1;
        end else begin
            b = dat;
        end
        return b;
    endfunction

    assign w_accept   = i_valid && o_ready;
    assign w_idle     = (r_phase == P_IDLE);
    // A command on an idle tick runs its first step at once; otherwise a step
    // runs only once the hold count has reached zero.
    assign w_run      = w_idle ? i_cmd_valid : (r_wait_count == 16'd0);
    assign w_step     = w_idle ? P_START_HI : r_phase;
    assign w_bi_inc   = r_byte_index + 3'd1;
    assign w_bc_inc   = r_bit_count + 4'd1;
    assign w_rd_shift = {r_shifter[6:0], i_sda_in};

    // Next phase and hold count.
    always_comb begin
        n_phase      = r_phase;
        n_wait_count = r_wait_count;
        if (!w_run) begin
            if (!w_idle) begin
                n_wait_count = r_wait_count - 16'd1;
            end
        end else begin
            n_wait_count = r_half_period;
            unique case (w_step)
                P_START_HI:   n_phase = P_START_FALL;
                P_START_FALL: n_phase = P_START_LOW;
                P_START_LOW:  n_phase = P_BIT_SET;
                P_BIT_SET:    n_phase = P_BIT_HI;
                P_BIT_HI:     n_phase = P_BIT_LO;
                P_BIT_LO:     n_phase = (w_bc_inc >= BITS_PER_BYTE) ? P_ACK_REL : P_BIT_SET;
                P_ACK_REL:    n_phase = P_ACK_HI;
                P_ACK_HI:     n_phase = P_ACK_POLL;
                P_ACK_POLL: begin
                    if (!i_sda_in) begin
                        if (w_bi_inc >= BYTES_SENT) begin
                            n_phase = (r_cmd_op == OP_READ) ? P_RD_HI : P_STOP_A;
                        end else if (w_bi_inc == RESTART_INDEX && r_cmd_op == OP_READ) begin
                            n_phase = P_START_HI;
                        end else begin
                            n_phase = P_BIT_SET;
                        end
                    end else if (r_ack_polls >= r_ack_timeout) begin
                        n_phase = P_STOP_B;
                    end else begin
                        // Another poll: the hold count stays at zero.
                        n_wait_count = r_wait_count;
                    end
                end
                P_RD_HI:      n_phase = P_RD_SAMPLE;
                P_RD_SAMPLE:  n_phase = (w_bc_inc >= BITS_PER_BYTE) ? P_NACK_REL : P_RD_HI;
                P_NACK_REL:   n_phase = P_NACK_HI;
                P_NACK_HI:    n_phase = P_NACK_LO;
                P_NACK_LO:    n_phase = P_STOP_A;
                P_STOP_A:     n_phase = P_STOP_B;
                P_STOP_B:     n_phase = P_STOP_C;
                P_STOP_C:     n_phase = P_FINISH;
                default: begin
                    n_phase      = P_IDLE;
                    n_wait_count = 16'd0;
                end
            endcase
        end
    end

    // Line levels, shifter, counters and flags.
    always_comb begin
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_shifter    = r_shifter;
        n_ack_polls  = r_ack_polls;
        n_cmd_op     = r_cmd_op;
        n_cmd_dev    = r_cmd_dev;
        n_cmd_reg    = r_cmd_reg;
        n_cmd_data   = r_cmd_data;
        n_read_hold  = r_read_hold;
        n_error      = r_error;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_done       = 1'b0;
        if (w_idle && i_cmd_valid) begin
            n_cmd_op     = i_opcode;
            n_cmd_dev    = i_device_byte;
            n_cmd_reg    = i_reg_addr;
            n_cmd_data   = i_write_data;
            n_error      = 1'b0;
            n_byte_index = 3'd0;
            n_bit_count  = 4'd0;
            n_ack_polls  = 8'd0;
        end
        if (w_run) begin
            unique case (w_step)
                P_START_HI: begin
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                end
                P_START_FALL: n_sda = 1'b0;
                P_START_LOW: begin
                    n_scl       = 1'b0;
                    n_shifter   = byte_for(r_byte_index, r_cmd_op, r_cmd_dev, r_cmd_reg,
                                           r_cmd_data);
                    n_bit_count = 4'd0;
                end
                P_BIT_SET: n_sda = r_shifter[7];
                P_BIT_HI:  n_scl = 1'b1;
                P_BIT_LO: begin
                    n_scl       = 1'b0;
                    n_shifter   = {r_shifter[6:0], 1'b0};
                    n_bit_count = w_bc_inc;
                end
                P_ACK_REL: n_sda = 1'b1;
                P_ACK_HI: begin
                    n_scl       = 1'b1;
                    n_ack_polls = 8'd0;
                end
                P_ACK_POLL: begin
                    if (!i_sda_in) begin
                        n_scl        = 1'b0;
                        n_ack_polls  = 8'd0;
                        n_byte_index = w_bi_inc;
                        if (w_bi_inc >= BYTES_SENT) begin
                            if (r_cmd_op == OP_READ) begin
                                n_shifter   = 8'd0;
                                n_bit_count = 4'd0;
                            end
                        end else if (!(w_bi_inc == RESTART_INDEX && r_cmd_op == OP_READ)) begin
                            n_shifter   = byte_for(w_bi_inc, r_cmd_op, r_cmd_dev, r_cmd_reg,
                                                   r_cmd_data);
                            n_bit_count = 4'd0;
                        end
                    end else if (r_ack_polls >= r_ack_timeout) begin
                        n_error = 1'b1;
                        n_sda   = 1'b0;
                        n_scl   = 1'b1;
                    end else begin
                        n_ack_polls = r_ack_polls + 8'd1;
                    end
                end
                P_RD_HI: n_scl = 1'b1;
                P_RD_SAMPLE: begin
                    n_shifter   = w_rd_shift;
                    n_scl       = 1'b0;
                    n_bit_count = w_bc_inc;
                    if (w_bc_inc >= BITS_PER_BYTE) begin
                        n_read_hold = w_rd_shift;
                    end
                end
                P_NACK_REL: n_sda = 1'b1;
                P_NACK_HI:  n_scl = 1'b1;
                P_NACK_LO:  n_scl = 1'b0;
                P_STOP_A: begin
                    n_sda = 1'b0;
                    n_scl = 1'b1;
                end
                P_STOP_B: ;
                P_STOP_C: n_sda = 1'b1;
                P_FINISH: n_done = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= P_IDLE;
            r_wait_count <= 16'd0;
            r_bit_count  <= 4'd0;
            r_byte_index <= 3'd0;
            r_shifter    <= 8'd0;
            r_ack_polls  <= 8'd0;
            r_cmd_op     <= OP_WRITE;
            r_cmd_dev    <= 8'd0;
            r_cmd_reg    <= 8'd0;
            r_cmd_data   <= 8'd0;
            r_read_hold  <= 8'd0;
            r_error      <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_shifter    <= n_shifter;
            r_ack_polls  <= n_ack_polls;
            r_cmd_op     <= n_cmd_op;
            r_cmd_dev    <= n_cmd_dev;
            r_cmd_reg    <= n_cmd_reg;
            r_cmd_data   <= n_cmd_data;
            r_read_hold  <= n_read_hold;
            r_error      <= n_error;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

    always_comb begin
        w_result.scl_level   = n_scl;
        w_result.sda_level   = n_sda;
        w_result.busy_res    = (n_phase != P_IDLE);
        w_result.done_res    = n_done;
        w_result.read_result = n_read_hold;
        w_result.no_ack      = n_error;
    end

    // The skid stage catches one result while the output register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= w_accept;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= w_result;
            end else begin
                r_out  <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_ready       = !r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_scl_level   = r_out.scl_level;
    assign o_sda_level   = r_out.sda_level;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_read_result = r_out.read_result;
    assign o_no_ack      = r_out.no_ack;

    // Configuration port.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_HALF_PERIOD: r_half_period <= pwdata[15:0];
                REG_ACK_TIMEOUT: r_ack_timeout <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HALF_PERIOD: prdata = {16'd0, r_half_period};
            REG_ACK_TIMEOUT: prdata = {24'd0, r_ack_timeout};
            default:         prdata = 32'd0;
        endcase
    end

    // A result may wait in the skid stage only behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    // A caught result stays until the output side drains.
    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid)
        else $error("skid result dropped during an output stall");

    // The sequencer only rests in idle with no hold pending.
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_IDLE) |-> (r_wait_count == 16'd0))
        else $error("hold count pending while idle");

    // The bit counter never passes one byte.
    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    // The final step of a transaction returns the sequencer to idle.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == P_FINISH && r_wait_count == 16'd0) |=> (r_phase == P_IDLE))
        else $error("sequencer did not return to idle after the stop condition");

endmodule
